FILE: rtl/gsbma_pkg.sv
package gsbma_pkg;

    localparam int RAW_W = 16;
    localparam int OUT_W = 20;
    localparam int AXES = 3;
    localparam int RANGE_W = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DEF_WINDOW_DEPTH = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RANGE_SELECT = 2'd0,
        CFG_BIAS_X       = 2'd1,
        CFG_BIAS_Y       = 2'd2,
        CFG_BIAS_Z       = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] scaled_x;
        logic signed [OUT_W-1:0] scaled_y;
        logic signed [OUT_W-1:0] scaled_z;
        logic signed [OUT_W-1:0] average_x;
        logic signed [OUT_W-1:0] average_y;
        logic signed [OUT_W-1:0] average_z;
    } out_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

FILE: rtl/gsbma_ram.sv
module gsbma_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/gsbma_div.sv
module gsbma_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [DIVIDEND_W-1:0]         dividend,
    input  logic [DIVISOR_W-1:0]                 divisor,
    output logic                                 done,
    output logic signed [gsbma_pkg::OUT_W-1:0]   quotient
);

    import gsbma_pkg::*;

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  neg_reg, neg_next;
    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;

    logic [DIVIDEND_W-1:0] magnitude;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;
    logic [DIVIDEND_W-1:0] q_signed;

    // restoring division, one quotient bit a cycle, msb first
    assign magnitude = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
    assign rem_shift = {rem_reg, q_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign fits      = (rem_shift >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W - 1);
            neg_next  = dividend[DIVIDEND_W-1];
            q_next    = magnitude;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // truncation toward zero: divide the magnitude, restore the sign
    assign q_signed = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign quotient = q_signed[OUT_W-1:0];
    assign done     = done_reg;

endmodule

FILE: rtl/gyro_scale_bias_moving_average.sv
// flow: the input beat is registered as scaled values, the window and running
// sums update, the shared bit-serial divider averages the three axes in turn,
// then the output register loads; no new beat is taken until that load
// reset: running sums, fill count, slot pointer, state, config and out_valid
// go to zero; the window RAM is not cleared, but unfilled slots read as zero
module gyro_scale_bias_moving_average #(
    parameter int WINDOW_DEPTH = gsbma_pkg::DEF_WINDOW_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  gsbma_pkg::in_t                        in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output gsbma_pkg::out_t                       out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gsbma_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gsbma_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import gsbma_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = OUT_W + CNT_W;
    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int ROW_W  = AXES * OUT_W;

    state_t state_reg, state_next;

    logic [RANGE_W-1:0]      range_reg;
    logic signed [RAW_W-1:0] bias_reg [AXES];

    logic signed [OUT_W-1:0] scaled_reg [AXES];
    logic signed [OUT_W-1:0] scaled_next [AXES];
    logic signed [OUT_W-1:0] avg_reg [AXES];
    logic signed [SUM_W-1:0] sum_reg [AXES];
    logic signed [SUM_W-1:0] sum_next [AXES];
    logic signed [OUT_W-1:0] old_val [AXES];
    logic signed [RAW_W-1:0] raw [AXES];

    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic [1:0]        axis_reg, axis_next;
    logic [1:0]        div_axis;

    logic              window_full;
    logic              accept;
    logic              load_out;
    logic              ram_we;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;

    div_ctrl_t               div_ctrl;
    logic signed [SUM_W-1:0] div_dividend;
    logic signed [OUT_W-1:0] div_quotient;

    logic   out_valid_reg, out_valid_next;
    out_t   out_data_reg;

    assign raw[0] = in_data.raw_x;
    assign raw[1] = in_data.raw_y;
    assign raw[2] = in_data.raw_z;

    assign accept      = in_valid && !in_stall;
    assign window_full = (fill_reg == CNT_W'(WINDOW_DEPTH));
    assign cfg_ready   = 1'b1;

    // scale by the range shift and take off the bias
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            scaled_next[a] = (OUT_W'(raw[a]) <<< range_reg) - OUT_W'(bias_reg[a]);
        end
    end

    // slots not yet written during warm-up read as zero
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            old_val[a] = window_full ? ram_rdata[a*OUT_W +: OUT_W] : '0;
            sum_next[a] = sum_reg[a] + SUM_W'(scaled_reg[a]) - SUM_W'(old_val[a]);
        end
    end

    assign ram_wdata = {scaled_reg[2], scaled_reg[1], scaled_reg[0]};

    gsbma_ram #(
        .WIDTH (ROW_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        div_axis = (state_reg == ST_START) ? 2'd0 : axis_reg + 2'd1;
        case (div_axis)
            2'd1:    div_dividend = sum_reg[1];
            2'd2:    div_dividend = sum_reg[2];
            default: div_dividend = sum_reg[0];
        endcase
    end

    gsbma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctrl.start),
        .dividend (div_dividend),
        .divisor  (fill_reg),
        .done     (div_ctrl.done),
        .quotient (div_quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_ctrl.done && axis_reg == 2'd2)
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall       = 1'b1;
        ram_we         = 1'b0;
        div_ctrl.start = 1'b0;
        load_out       = 1'b0;
        axis_next      = axis_reg;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_UPDATE:
            begin
                ram_we    = 1'b1;
                axis_next = 2'd0;
                if (!window_full)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                if (slot_reg == ADDR_W'(WINDOW_DEPTH - 1))
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_START:
            begin
                div_ctrl.start = 1'b1;
            end
            ST_DIVIDE:
            begin
                if (div_ctrl.done)
                begin
                    axis_next = axis_reg + 2'd1;
                    if (axis_reg != 2'd2)
                    begin
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            ST_OUTPUT:
            begin
                load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            fill_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            range_reg     <= '0;
            for (int a = 0; a < AXES; a++)
            begin
                bias_reg[a] <= '0;
                sum_reg[a]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_RANGE_SELECT: range_reg   <= cfg_data[RANGE_W-1:0];
                    CFG_BIAS_X:       bias_reg[0] <= cfg_data;
                    CFG_BIAS_Y:       bias_reg[1] <= cfg_data;
                    CFG_BIAS_Z:       bias_reg[2] <= cfg_data;
                    default:          range_reg   <= range_reg;
                endcase
            end
            if (state_reg == ST_UPDATE)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    sum_reg[a] <= sum_next[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                scaled_reg[a] <= scaled_next[a];
            end
        end
        if (state_reg == ST_DIVIDE && div_ctrl.done)
        begin
            case (axis_reg)
                2'd1:    avg_reg[1] <= div_quotient;
                2'd2:    avg_reg[2] <= div_quotient;
                default: avg_reg[0] <= div_quotient;
            endcase
        end
        if (load_out)
        begin
            out_data_reg.scaled_x  <= scaled_reg[0];
            out_data_reg.scaled_y  <= scaled_reg[1];
            out_data_reg.scaled_z  <= scaled_reg[2];
            out_data_reg.average_x <= avg_reg[0];
            out_data_reg.average_y <= avg_reg[1];
            out_data_reg.average_z <= avg_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
